/* rtl/cdamt_pkg.sv */
// shared types, constants and helpers for the display aux mode tracker
package cdamt_pkg;

   localparam int unsigned ID_WIDTH      = 29;
   localparam int unsigned WINDOW_WIDTH  = 16;
   localparam int unsigned LEVEL_WIDTH   = 8;
   localparam int unsigned CSR_IDX_WIDTH = 2;

   localparam logic [ID_WIDTH-1:0]     WATCH_ID_RESET  = 29'h151;
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET    = 16'd200;
   localparam logic [LEVEL_WIDTH-1:0]  THRESHOLD_RESET = 8'h59;
   localparam logic [WINDOW_WIDTH-1:0] ELAPSED_MAX     = 16'hFFFF;

   localparam logic [7:0] HEADER_MARK = 8'h10;
   localparam logic [7:0] TEXT_MARK   = 8'h21;
   localparam logic [3:0] MIN_LENGTH  = 4'd8;

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_FRAME = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_WATCH_ID  = 2'd0,
      CSR_WINDOW_MS = 2'd1,
      CSR_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                kind;
      logic [ID_WIDTH-1:0] frame_id;
      logic [3:0]          frame_length;
      logic [7:0]          byte_0;
      logic [7:0]          byte_1;
      logic [7:0]          byte_2;
      logic [7:0]          byte_3;
      logic [7:0]          byte_4;
      logic [7:0]          byte_5;
      logic [7:0]          byte_6;
      logic [7:0]          byte_7;
   } req_type;

   typedef struct packed {
      logic aux_active;
      logic mode_changed;
   } rsp_type;

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic sp_or_dig(input logic [7:0] c);
      return (c == 8'h20) || is_dig(c);
   endfunction

endpackage

/* rtl/cdamt_classify.sv */
// text frame classifier: new aux flag from the display text and header level
module cdamt_classify (
   input  cdamt_pkg::req_type                    item,
   input  logic [cdamt_pkg::LEVEL_WIDTH-1:0]     header_level,
   input  logic [cdamt_pkg::LEVEL_WIDTH-1:0]     level_threshold,
   input  logic                                  aux_flag,
   output logic                                  aux_next
);

   localparam logic [7:0] CHAR_SP = 8'h20;
   localparam logic [7:0] CHAR_A  = 8'h41;
   localparam logic [7:0] CHAR_U  = 8'h55;
   localparam logic [7:0] CHAR_X  = 8'h58;
   localparam logic [7:0] CHAR_T  = 8'h54;
   localparam logic [7:0] CHAR_R  = 8'h52;
   localparam logic [7:0] CHAR_C  = 8'h43;
   localparam logic [7:0] CHAR_M  = 8'h4D;
   localparam logic [7:0] CHAR_L  = 8'h4C;
   localparam logic [7:0] CHAR_GT = 8'h3E;

   logic level_high;
   logic hit_aux;
   logic hit_cd;
   logic hit_radio_short;
   logic hit_radio_m;
   logic hit_three_space;
   logic hit_radio_l;

   assign level_high = (header_level >= level_threshold);

   assign hit_aux = (item.byte_1 == CHAR_A) && (item.byte_2 == CHAR_U) &&
                    (item.byte_3 == CHAR_X);

   assign hit_cd = (item.byte_1 == CHAR_T) && (item.byte_2 == CHAR_R) &&
                   (item.byte_3 == CHAR_SP) && cdamt_pkg::sp_or_dig(item.byte_4) &&
                   cdamt_pkg::is_dig(item.byte_5) && (item.byte_6 == CHAR_SP) &&
                   (item.byte_7 == CHAR_C);

   assign hit_radio_short = (item.byte_1 == CHAR_GT) && (item.byte_2 == CHAR_SP) &&
                            (item.byte_3 != CHAR_SP) && level_high;

   assign hit_radio_m = (item.byte_1 == CHAR_M) && (item.byte_2 == CHAR_SP) &&
                        cdamt_pkg::sp_or_dig(item.byte_3) && cdamt_pkg::is_dig(item.byte_4) &&
                        cdamt_pkg::is_dig(item.byte_5) && cdamt_pkg::is_dig(item.byte_6) &&
                        (item.byte_7 == CHAR_SP);

   // byte 7 is never looked at in this pattern
   assign hit_three_space = (item.byte_1 == CHAR_SP) && (item.byte_2 == CHAR_SP) &&
                            (item.byte_3 == CHAR_SP) && cdamt_pkg::is_dig(item.byte_4) &&
                            cdamt_pkg::is_dig(item.byte_5) && cdamt_pkg::is_dig(item.byte_6) &&
                            !level_high;

   assign hit_radio_l = (item.byte_1 == CHAR_L) && (item.byte_2 == CHAR_SP) &&
                        (item.byte_3 == CHAR_SP) && cdamt_pkg::is_dig(item.byte_4) &&
                        cdamt_pkg::is_dig(item.byte_5) && cdamt_pkg::is_dig(item.byte_6) &&
                        (item.byte_7 == CHAR_SP);

   always_comb begin
      if (hit_aux) begin
         aux_next = 1'b1;
      end else if (hit_cd || hit_radio_short || hit_radio_m || hit_three_space ||
                   hit_radio_l) begin
         aux_next = 1'b0;
      end else begin
         aux_next = aux_flag;
      end
   end

endmodule

/* rtl/can_display_aux_mode_tracker.sv */
// top level of the display aux mode tracker: input stage, state, result register
//
//   port group | direction | handshake             | beat
//   req_       | in        | req_valid / req_ready | one tick or one can frame
//   rsp_       | out       | rsp_valid / rsp_ready | aux flag and change mark
//   csr_       | in        | csr_valid / csr_ready | register index and data
//
// a beat goes through two registers: the input stage, then the result register
// where the tracker state is updated, with the single classify pass between the
// two registers; one beat per cycle is sustained while rsp_ready stays high.
// synchronous reset clears valids, state and configuration to their defaults.
// a stalled result holds the input stage; req_ready drops only when both are full.
module can_display_aux_mode_tracker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  cdamt_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output cdamt_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cdamt_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [cdamt_pkg::ID_WIDTH-1:0]         csr_data
);

   logic                                  s1_valid_ff;
   cdamt_pkg::req_type                    s1_ff;
   logic                                  rsp_valid_ff;
   cdamt_pkg::rsp_type                    rsp_ff;
   cdamt_pkg::rsp_type                    rsp_in;

   logic [cdamt_pkg::ID_WIDTH-1:0]        watch_id_ff;
   logic [cdamt_pkg::WINDOW_WIDTH-1:0]    window_ms_ff;
   logic [cdamt_pkg::LEVEL_WIDTH-1:0]     threshold_ff;

   logic                                  aux_flag_ff;
   logic                                  aux_flag_in;
   logic [cdamt_pkg::LEVEL_WIDTH-1:0]     header_level_ff;
   logic [cdamt_pkg::LEVEL_WIDTH-1:0]     header_level_in;
   logic [cdamt_pkg::WINDOW_WIDTH-1:0]    elapsed_ms_ff;
   logic [cdamt_pkg::WINDOW_WIDTH-1:0]    elapsed_ms_in;

   logic                                  advance;
   logic                                  take_req;
   logic                                  frame_hit;
   logic                                  aux_classified;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take_req  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign frame_hit = (s1_ff.kind == cdamt_pkg::KIND_FRAME) &&
                      (s1_ff.frame_id == watch_id_ff) &&
                      (s1_ff.frame_length >= cdamt_pkg::MIN_LENGTH);

   cdamt_classify u_classify (
      .item            (s1_ff),
      .header_level    (header_level_ff),
      .level_threshold (threshold_ff),
      .aux_flag        (aux_flag_ff),
      .aux_next        (aux_classified)
   );

   always_comb begin
      aux_flag_in     = aux_flag_ff;
      header_level_in = header_level_ff;
      elapsed_ms_in   = elapsed_ms_ff;
      if (s1_ff.kind == cdamt_pkg::KIND_TICK) begin
         if (elapsed_ms_ff != cdamt_pkg::ELAPSED_MAX) begin
            elapsed_ms_in = elapsed_ms_ff + 16'd1;
         end
      end else if (frame_hit) begin
         if (s1_ff.byte_0 == cdamt_pkg::HEADER_MARK) begin
            header_level_in = s1_ff.byte_6;
            elapsed_ms_in   = '0;
         end else if ((s1_ff.byte_0 == cdamt_pkg::TEXT_MARK) &&
                      (elapsed_ms_ff < window_ms_ff)) begin
            aux_flag_in = aux_classified;
         end
      end
      rsp_in.aux_active   = aux_flag_in;
      rsp_in.mode_changed = aux_flag_in != aux_flag_ff;
   end

   // control, state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         aux_flag_ff     <= 1'b0;
         header_level_ff <= '0;
         elapsed_ms_ff   <= '0;
         watch_id_ff     <= cdamt_pkg::WATCH_ID_RESET;
         window_ms_ff    <= cdamt_pkg::WINDOW_RESET;
         threshold_ff    <= cdamt_pkg::THRESHOLD_RESET;
      end else begin
         if (take_req) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            aux_flag_ff     <= aux_flag_in;
            header_level_ff <= header_level_in;
            elapsed_ms_ff   <= elapsed_ms_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (cdamt_pkg::csr_index_type'(csr_index))
               cdamt_pkg::CSR_WATCH_ID:  watch_id_ff  <= csr_data;
               cdamt_pkg::CSR_WINDOW_MS: window_ms_ff <= csr_data[cdamt_pkg::WINDOW_WIDTH-1:0];
               cdamt_pkg::CSR_THRESHOLD: threshold_ff <= csr_data[cdamt_pkg::LEVEL_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   a_flag_matches_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ff.aux_active == aux_flag_ff))
      else $error("result flag differs from tracker state");

   a_change_mark: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ff.mode_changed == (aux_flag_ff != $past(aux_flag_ff))))
      else $error("change mark does not match flag transition");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(aux_flag_ff) && $stable(header_level_ff) &&
                    $stable(elapsed_ms_ff)))
      else $error("tracker state moved without a beat");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("input stage lost a beat while stalled");

endmodule

/* tb/aux_mode_checker.sv */
// checker for the display aux mode tracker: tracks state, predicts each result beat and compares
module aux_mode_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  cdamt_pkg::req_type                  req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  cdamt_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [cdamt_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [cdamt_pkg::ID_WIDTH-1:0]      csr_data,
   output int                                  mismatch_count,
   output int                                  beats_owed
);

   import cdamt_pkg::*;

   typedef logic [0:7][7:0] text_type;

   logic [ID_WIDTH-1:0]     watch_id;
   logic [WINDOW_WIDTH-1:0] window_ms;
   logic [LEVEL_WIDTH-1:0]  threshold;

   logic                    aux_flag;
   logic [7:0]              header_level;
   logic [WINDOW_WIDTH-1:0] elapsed_ms;

   rsp_type mode_queue[$];
   rsp_type want;

   function automatic logic numeral(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic blank_or_numeral(input logic [7:0] c);
      return (c == " ") || numeral(c);
   endfunction

   // new flag value for an accepted text frame, patterns tried in display order
   function automatic logic text_verdict(input text_type t);
      if (t[1] == "A" && t[2] == "U" && t[3] == "X")
         return 1'b1;
      if (t[1] == "T" && t[2] == "R" && t[3] == " " && blank_or_numeral(t[4]) &&
          numeral(t[5]) && t[6] == " " && t[7] == "C")
         return 1'b0;
      if (t[1] == ">" && t[2] == " " && t[3] != " " && header_level >= threshold)
         return 1'b0;
      if (t[1] == "M" && t[2] == " " && blank_or_numeral(t[3]) && numeral(t[4]) &&
          numeral(t[5]) && numeral(t[6]) && t[7] == " ")
         return 1'b0;
      // byte 7 is never looked at here
      if (t[1] == " " && t[2] == " " && t[3] == " " && numeral(t[4]) &&
          numeral(t[5]) && numeral(t[6]) && header_level < threshold)
         return 1'b0;
      if (t[1] == "L" && t[2] == " " && t[3] == " " && numeral(t[4]) &&
          numeral(t[5]) && numeral(t[6]) && t[7] == " ")
         return 1'b0;
      return aux_flag;
   endfunction

   task automatic advance_tracker(input req_type beat, output rsp_type result);
      logic     was_aux;
      text_type t;
      was_aux = aux_flag;
      t = {beat.byte_0, beat.byte_1, beat.byte_2, beat.byte_3,
           beat.byte_4, beat.byte_5, beat.byte_6, beat.byte_7};
      if (beat.kind == KIND_TICK) begin
         if (elapsed_ms != ELAPSED_MAX)
            elapsed_ms = elapsed_ms + 16'd1;
      end else if (beat.frame_id == watch_id && beat.frame_length >= MIN_LENGTH) begin
         if (t[0] == HEADER_MARK) begin
            header_level = t[6];
            elapsed_ms = '0;
         end else if (t[0] == TEXT_MARK && elapsed_ms < window_ms) begin
            aux_flag = text_verdict(t);
         end
      end
      result.aux_active = aux_flag;
      result.mode_changed = aux_flag != was_aux;
   endtask

   task automatic report_mismatch(input string what, input logic expected, input logic got);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("mismatch at %0t: %s expected %b got %b", $time, what, expected, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         watch_id = WATCH_ID_RESET;
         window_ms = WINDOW_RESET;
         threshold = THRESHOLD_RESET;
         aux_flag = 1'b0;
         header_level = '0;
         elapsed_ms = '0;
         mode_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mode_queue.size() == 0) begin
               report_mismatch("result beat with nothing owed", 1'b0, 1'b1);
            end else begin
               want = mode_queue.pop_front();
               if (rsp_data.aux_active !== want.aux_active)
                  report_mismatch("aux_active", want.aux_active, rsp_data.aux_active);
               if (rsp_data.mode_changed !== want.mode_changed)
                  report_mismatch("mode_changed", want.mode_changed, rsp_data.mode_changed);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_WATCH_ID:  watch_id = csr_data;
               CSR_WINDOW_MS: window_ms = csr_data[WINDOW_WIDTH-1:0];
               CSR_THRESHOLD: threshold = csr_data[LEVEL_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_tracker(req_data, want);
            mode_queue.push_back(want);
         end
      end
      beats_owed = mode_queue.size();
   end

endmodule

/* tb/testbench.sv */
// testbench top for the display aux mode tracker: clock, reset, stimulus and verdict
module testbench;

   import cdamt_pkg::*;

   typedef logic [0:7][7:0] text_type;

   typedef enum int {
      READY_RUN,
      READY_HOLD,
      READY_MIXED
   } ready_shape_type;

   localparam int unsigned LIMIT_CYCLES = 8_000_000;

   localparam text_type AUX_TEXT   = {TEXT_MARK, "AUXILIA"};
   localparam text_type CD_TEXT    = {TEXT_MARK, "TR  9 C"};
   localparam text_type SHORT_TEXT = {TEXT_MARK, "> FM 87"};
   localparam text_type M_TEXT     = {TEXT_MARK, "M 0123 "};
   localparam text_type SPACE_TEXT = {TEXT_MARK, "   456Z"};
   localparam text_type L_TEXT     = {TEXT_MARK, "L  789 "};
   localparam text_type OTHER_TEXT = {TEXT_MARK, "HELLO  "};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [ID_WIDTH-1:0]      csr_data = '0;

   int mismatch_count;
   int beats_owed;

   logic [ID_WIDTH-1:0]     cur_watch = WATCH_ID_RESET;
   logic [WINDOW_WIDTH-1:0] cur_window = WINDOW_RESET;
   logic [LEVEL_WIDTH-1:0]  cur_thr = THRESHOLD_RESET;

   int burst_left = 0;
   bit steady = 1'b0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;

   always #6 clock = ~clock;

   can_display_aux_mode_tracker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   aux_mode_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .beats_owed     (beats_owed)
   );

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_blank_or_digit();
      return $urandom_range(0, 1) ? 8'h20 : rand_digit();
   endfunction

   function automatic logic [3:0] pick_length();
      return ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) : MIN_LENGTH;
   endfunction

   // header levels cluster around the threshold so both radio variants show up
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 3))
         0: return cur_thr - 8'd1;
         1: return cur_thr;
         2: return cur_thr + 8'd1;
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic text_type pattern_text();
      text_type t;
      int       pos;
      t = {$urandom(), $urandom()};
      t[0] = TEXT_MARK;
      case ($urandom_range(0, 6))
         0: {t[1], t[2], t[3]} = "AUX";
         1: begin
            {t[1], t[2], t[3]} = "TR ";
            t[4] = rand_blank_or_digit();
            t[5] = rand_digit();
            t[6] = " ";
            t[7] = "C";
         end
         2: begin
            {t[1], t[2]} = "> ";
            if (t[3] == " ")
               t[3] = "!";
         end
         3: begin
            {t[1], t[2]} = "M ";
            t[3] = rand_blank_or_digit();
            t[4] = rand_digit();
            t[5] = rand_digit();
            t[6] = rand_digit();
            t[7] = " ";
         end
         4: begin
            {t[1], t[2], t[3]} = "   ";
            t[4] = rand_digit();
            t[5] = rand_digit();
            t[6] = rand_digit();
         end
         5: begin
            {t[1], t[2], t[3]} = "L  ";
            t[4] = rand_digit();
            t[5] = rand_digit();
            t[6] = rand_digit();
            t[7] = " ";
         end
         default: ;
      endcase
      // near misses: one character set just outside the digit range, to a blank or to a random byte
      if ($urandom_range(0, 3) == 0) begin
         pos = $urandom_range(1, 7);
         case ($urandom_range(0, 3))
            0: t[pos] = 8'h2F;
            1: t[pos] = 8'h3A;
            2: t[pos] = " ";
            default: t[pos] = 8'($urandom());
         endcase
      end
      return t;
   endfunction

   task automatic send_item(input req_type beat);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_tick();
      req_type beat;
      {beat.frame_id, beat.frame_length} = 33'({$urandom(), $urandom()});
      {beat.byte_0, beat.byte_1, beat.byte_2, beat.byte_3} = $urandom();
      {beat.byte_4, beat.byte_5, beat.byte_6, beat.byte_7} = $urandom();
      beat.kind = KIND_TICK;
      send_item(beat);
   endtask

   task automatic send_frame(input logic [ID_WIDTH-1:0] id, input logic [3:0] len,
                             input text_type t);
      req_type beat;
      beat.kind = KIND_FRAME;
      beat.frame_id = id;
      beat.frame_length = len;
      {beat.byte_0, beat.byte_1, beat.byte_2, beat.byte_3,
       beat.byte_4, beat.byte_5, beat.byte_6, beat.byte_7} = t;
      send_item(beat);
   endtask

   task automatic send_header(input logic [7:0] level);
      text_type t;
      t = {$urandom(), $urandom()};
      t[0] = HEADER_MARK;
      t[6] = level;
      send_frame(cur_watch, pick_length(), t);
   endtask

   // frames the block ignores unless a random mark byte matches, plus stray ticks
   task automatic send_noise();
      text_type            t;
      logic [ID_WIDTH-1:0] id;
      t = {$urandom(), $urandom()};
      if ($urandom_range(0, 1))
         t[0] = $urandom_range(0, 1) ? HEADER_MARK : TEXT_MARK;
      case ($urandom_range(0, 3))
         0: send_tick();
         1: begin
            if ($urandom_range(0, 1))
               id = cur_watch ^ (29'd1 << $urandom_range(0, ID_WIDTH - 1));
            else
               id = ID_WIDTH'($urandom());
            if (id == cur_watch)
               id = ~id;
            send_frame(id, pick_length(), t);
         end
         2: send_frame(cur_watch, 4'($urandom_range(0, 7)), t);
         default: begin
            t[0] = 8'($urandom());
            send_frame(cur_watch, pick_length(), t);
         end
      endcase
   endtask

   // header, then text frames with ticks in between that may run out the window
   task automatic play_sequence(inout int made);
      int texts;
      int ticks;
      send_header(pick_level());
      made++;
      texts = $urandom_range(1, 3);
      repeat (texts) begin
         if (cur_window <= 40)
            ticks = $urandom_range(0, cur_window / 2 + 1);
         else
            ticks = $urandom_range(0, 2);
         repeat (ticks) send_tick();
         send_frame(cur_watch, pick_length(), pattern_text());
         made += ticks + 1;
      end
   endtask

   task automatic random_run(input int count);
      int made;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 3) == 0) begin
            send_noise();
            made++;
         end else begin
            play_sequence(made);
         end
      end
   endtask

   task automatic drain();
      int waited;
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      waited = 0;
      while (beats_owed != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [ID_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WATCH_ID:  cur_watch = value;
         CSR_WINDOW_MS: cur_window = value[WINDOW_WIDTH-1:0];
         CSR_THRESHOLD: cur_thr = value[LEVEL_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [ID_WIDTH-1:0] watch, input logic [15:0] window,
                             input logic [7:0] thr);
      write_reg(CSR_WATCH_ID, watch);
      write_reg(CSR_WINDOW_MS, ID_WIDTH'(window));
      write_reg(CSR_THRESHOLD, ID_WIDTH'(thr));
   endtask

   // receiver: runs, short stalls and mixed patterns, one long hold early in the random part
   initial begin : receiver
      ready_shape_type shape;
      int              span;
      forever begin
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            shape = READY_HOLD;
            span = 80;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  shape = READY_RUN;
                  span = $urandom_range(1, 40);
               end
               3, 4: begin
                  shape = READY_HOLD;
                  span = $urandom_range(1, 8);
               end
               default: begin
                  shape = READY_MIXED;
                  span = $urandom_range(4, 30);
               end
            endcase
         end
         repeat (span) begin
            @(negedge clock);
            rsp_ready <= (shape == READY_RUN) ||
                         (shape == READY_MIXED && $urandom_range(0, 3) != 0);
         end
      end
   end

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("can_display_aux_mode_tracker test failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass at the reset settings; text before any header is in window
      send_tick();
      send_frame(cur_watch, MIN_LENGTH, AUX_TEXT);
      send_header(cur_thr);
      send_frame(cur_watch, MIN_LENGTH, SHORT_TEXT);
      send_frame(cur_watch, MIN_LENGTH, AUX_TEXT);
      send_frame(cur_watch, MIN_LENGTH, CD_TEXT);
      send_frame(cur_watch, MIN_LENGTH, AUX_TEXT);
      send_frame(cur_watch, MIN_LENGTH, M_TEXT);
      send_frame(cur_watch, MIN_LENGTH, AUX_TEXT);
      send_header(cur_thr - 8'd1);
      send_frame(cur_watch, MIN_LENGTH, SPACE_TEXT);
      send_frame(cur_watch, MIN_LENGTH, AUX_TEXT);
      send_frame(cur_watch, MIN_LENGTH, SHORT_TEXT);
      send_frame(cur_watch, MIN_LENGTH, L_TEXT);
      send_frame(cur_watch, MIN_LENGTH, OTHER_TEXT);
      send_frame(cur_watch, MIN_LENGTH, AUX_TEXT);
      send_frame(cur_watch ^ 29'd1, MIN_LENGTH, CD_TEXT);
      send_frame(cur_watch, 4'd7, CD_TEXT);
      send_frame(cur_watch, MIN_LENGTH, {8'h22, CD_TEXT[1:7]});
      send_frame(cur_watch, 4'd15, CD_TEXT);
      send_frame(cur_watch, 4'd0, AUX_TEXT);
      send_header(8'hFF);
      send_frame(cur_watch, MIN_LENGTH, AUX_TEXT);
      send_frame(cur_watch ^ 29'h1000_0000, MIN_LENGTH, {HEADER_MARK, 56'h0});
      send_frame(cur_watch, MIN_LENGTH, SHORT_TEXT);
      hold_armed = 1'b1;
      random_run(100);
      drain();

      // one-millisecond window: only a text frame right after its header counts
      set_config(ID_WIDTH'($urandom()), 16'd1, 8'd0);
      send_header(8'd0);
      send_frame(cur_watch, MIN_LENGTH, AUX_TEXT);
      send_tick();
      send_frame(cur_watch, MIN_LENGTH, CD_TEXT);
      send_header(8'd0);
      send_frame(cur_watch, MIN_LENGTH, CD_TEXT);
      random_run(80);
      drain();

      set_config({ID_WIDTH{1'b1}}, 16'hFFFF, 8'hFF);
      random_run(80);
      drain();

      set_config('0, 16'($urandom_range(2, 12)), 8'($urandom()));
      random_run(150);
      drain();

      set_config(ID_WIDTH'($urandom()), 16'($urandom_range(20, 40)), 8'($urandom()));
      random_run(150);
      drain();

      // window edge: last in-window millisecond, then past it
      set_config(WATCH_ID_RESET, 16'd5, THRESHOLD_RESET);
      steady = 1'b1;
      send_frame(cur_watch, MIN_LENGTH, CD_TEXT);
      send_header(8'd0);
      repeat (4) send_tick();
      send_frame(cur_watch, MIN_LENGTH, AUX_TEXT);
      send_tick();
      send_tick();
      send_frame(cur_watch, MIN_LENGTH, CD_TEXT);
      drain();

      if (mismatch_count == 0 && beats_owed == 0)
         $display("can_display_aux_mode_tracker test passed");
      else
         $display("can_display_aux_mode_tracker test failed");
      $finish;
   end

endmodule

/* can_display_aux_mode_tracker.f */
rtl/cdamt_pkg.sv
rtl/cdamt_classify.sv
rtl/can_display_aux_mode_tracker.sv
tb/aux_mode_checker.sv
tb/testbench.sv
